// File: hdl/fes_pkg.sv
`default_nettype none

package fes_pkg;

  // Default geometry of the emulated store.
  localparam int STORE_BYTES_DEF = 1024;
  localparam int PAGE_BYTES_DEF  = 128;

  // Field widths of the item, the result and the region register.
  localparam int OP_W     = 3;
  localparam int ADDR_W   = 16;
  localparam int PAGE_W   = 8;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int ERASED_W = 4;
  localparam int PROG_W   = 8;
  localparam int REGION_W = 11;

  // Width of byte positions and page limits compared against the region size.
  localparam int EXT_W = 17;

  localparam logic [REGION_W-1:0] REGION_RESET = 11'd1024;
  localparam logic [BYTE_W-1:0]   ERASED_BYTE  = 8'hFF;
  localparam logic [ERASED_W-1:0] ERASED_MAX   = 4'd15;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ       = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd1;
  localparam logic [OP_W-1:0] OP_VERIFY     = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE_PAGE = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE_ALL  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

  // Microprogram addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UA_CLEAR    = 4'd0;
  localparam logic [UPC_W-1:0] UA_IDLE     = 4'd1;
  localparam logic [UPC_W-1:0] UA_RD_FIN   = 4'd2;
  localparam logic [UPC_W-1:0] UA_WR_FIN   = 4'd3;
  localparam logic [UPC_W-1:0] UA_VF_FIN   = 4'd4;
  localparam logic [UPC_W-1:0] UA_EP_SETUP = 4'd5;
  localparam logic [UPC_W-1:0] UA_EP_WALK  = 4'd6;
  localparam logic [UPC_W-1:0] UA_EA_SETUP = 4'd7;
  localparam logic [UPC_W-1:0] UA_EA_WALK  = 4'd8;
  localparam logic [UPC_W-1:0] UA_ER_FIN   = 4'd9;
  localparam logic [UPC_W-1:0] UA_BAD      = 4'd10;

  // Which result a finishing step produces.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_READ,
    RES_WRITE,
    RES_VERIFY,
    RES_ERASE,
    RES_INVALID
  } res_t;

  // Datapath action of a step.
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SETUP_PAGE,
    ACT_SETUP_ALL,
    ACT_WALK
  } act_t;

  // Memory write of a step.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_FF,
    WR_DATA
  } wr_t;

  // Branch condition of a step.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ITEM,
    C_OUT_FREE,
    C_CLR_DONE,
    C_PAGE_BAD,
    C_NO_PAGES,
    C_PAGE_END,
    C_ALL_END
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic             take;
    logic             emit;
    logic             dispatch;
    logic             stay;
    res_t             res;
    act_t             act;
    wr_t              wr;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctl_t;

  // Conditions reported by the datapath to the sequencer.
  typedef struct packed {
    logic            item;
    logic            out_free;
    logic            clr_done;
    logic            page_bad;
    logic            no_pages;
    logic            page_end;
    logic            all_end;
    logic [OP_W-1:0] op;
  } flags_t;

  function automatic ctl_t mk(input logic take, input logic emit, input logic dispatch,
                              input logic stay, input res_t res, input act_t act,
                              input wr_t wr, input cond_t cond,
                              input logic [UPC_W-1:0] target);
    ctl_t w;
    w.take     = take;
    w.emit     = emit;
    w.dispatch = dispatch;
    w.stay     = stay;
    w.res      = res;
    w.act      = act;
    w.wr       = wr;
    w.cond     = cond;
    w.target   = target;
    return w;
  endfunction

  // Control store. If its condition holds, a step jumps to its target, or on
  // dispatch to the op's entry; else it repeats or falls to the next address.
  function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
    ctl_t w;
    unique case (a)
      UA_CLEAR:    w = mk(1'b0, 1'b0, 1'b0, 1'b1, RES_NONE, ACT_WALK, WR_FF,
                          C_CLR_DONE, UA_IDLE);
      UA_IDLE:     w = mk(1'b1, 1'b0, 1'b1, 1'b1, RES_NONE, ACT_NONE, WR_NONE,
                          C_ITEM, UA_IDLE);
      UA_RD_FIN:   w = mk(1'b0, 1'b1, 1'b0, 1'b1, RES_READ, ACT_NONE, WR_NONE,
                          C_OUT_FREE, UA_IDLE);
      UA_WR_FIN:   w = mk(1'b0, 1'b1, 1'b0, 1'b1, RES_WRITE, ACT_NONE, WR_DATA,
                          C_OUT_FREE, UA_IDLE);
      UA_VF_FIN:   w = mk(1'b0, 1'b1, 1'b0, 1'b1, RES_VERIFY, ACT_NONE, WR_NONE,
                          C_OUT_FREE, UA_IDLE);
      UA_EP_SETUP: w = mk(1'b0, 1'b0, 1'b0, 1'b0, RES_NONE, ACT_SETUP_PAGE, WR_NONE,
                          C_PAGE_BAD, UA_BAD);
      UA_EP_WALK:  w = mk(1'b0, 1'b0, 1'b0, 1'b1, RES_NONE, ACT_WALK, WR_FF,
                          C_PAGE_END, UA_ER_FIN);
      UA_EA_SETUP: w = mk(1'b0, 1'b0, 1'b0, 1'b0, RES_NONE, ACT_SETUP_ALL, WR_NONE,
                          C_NO_PAGES, UA_ER_FIN);
      UA_EA_WALK:  w = mk(1'b0, 1'b0, 1'b0, 1'b1, RES_NONE, ACT_WALK, WR_FF,
                          C_ALL_END, UA_ER_FIN);
      UA_ER_FIN:   w = mk(1'b0, 1'b1, 1'b0, 1'b1, RES_ERASE, ACT_NONE, WR_NONE,
                          C_OUT_FREE, UA_IDLE);
      UA_BAD:      w = mk(1'b0, 1'b1, 1'b0, 1'b1, RES_INVALID, ACT_NONE, WR_NONE,
                          C_OUT_FREE, UA_IDLE);
      default:     w = mk(1'b0, 1'b0, 1'b0, 1'b0, RES_NONE, ACT_NONE, WR_NONE,
                          C_ALWAYS, UA_IDLE);
    endcase
    return w;
  endfunction

  // Entry point of the routine for each operation code.
  function automatic logic [UPC_W-1:0] entry(input logic [OP_W-1:0] op);
    logic [UPC_W-1:0] e;
    unique case (op)
      OP_READ:       e = UA_RD_FIN;
      OP_WRITE:      e = UA_WR_FIN;
      OP_VERIFY:     e = UA_VF_FIN;
      OP_ERASE_PAGE: e = UA_EP_SETUP;
      OP_ERASE_ALL:  e = UA_EA_SETUP;
      default:       e = UA_BAD;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: hdl/fes_mem.sv
`default_nettype none

module fes_mem #(
  parameter int DEPTH = fes_pkg::STORE_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [fes_pkg::BYTE_W-1:0]   rd_data,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [fes_pkg::BYTE_W-1:0]   wr_data
);

  logic [fes_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [fes_pkg::BYTE_W-1:0] rd_data_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/fes_seq.sv
`default_nettype none

module fes_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fes_pkg::flags_t flags,
  output fes_pkg::ctl_t        ctl
);

  logic [fes_pkg::UPC_W-1:0] upc_r;
  logic [fes_pkg::UPC_W-1:0] upc_nxt;
  logic                      taken;

  // Control word of the current step.
  assign ctl = fes_pkg::ucode(upc_r);

  // Condition select.
  always_comb begin
    unique case (ctl.cond)
      fes_pkg::C_ALWAYS:   taken = 1'b1;
      fes_pkg::C_ITEM:     taken = flags.item;
      fes_pkg::C_OUT_FREE: taken = flags.out_free;
      fes_pkg::C_CLR_DONE: taken = flags.clr_done;
      fes_pkg::C_PAGE_BAD: taken = flags.page_bad;
      fes_pkg::C_NO_PAGES: taken = flags.no_pages;
      fes_pkg::C_PAGE_END: taken = flags.page_end;
      fes_pkg::C_ALL_END:  taken = flags.all_end;
      default:             taken = 1'b0;
    endcase
  end

  // Next microprogram address: jump, dispatch on the operation, hold or step on.
  always_comb begin
    if (taken) begin
      upc_nxt = ctl.dispatch ? fes_pkg::entry(flags.op) : ctl.target;
    end else if (ctl.stay) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + fes_pkg::UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= fes_pkg::UA_CLEAR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/flash_eeprom_emulation_store.sv
// Read, write, verify and unknown operations go from acceptance straight to the finishing step that loads the result.
// Erase page walks the bytes of the page, or reports invalid when the page is out of range;
// erase all walks the n whole pages in the region.
// An erase writes one byte a cycle through the single memory write port.
// One item at a time; the next item is taken as soon as the result is in the output register.
// After reset the store is filled with 0xFF, with input stalled.
`default_nettype none

module flash_eeprom_emulation_store #(
  parameter int STORE_BYTES = fes_pkg::STORE_BYTES_DEF,
  parameter int PAGE_BYTES  = fes_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fes_pkg::OP_W-1:0]        in_operation,
  input  wire logic [fes_pkg::ADDR_W-1:0]      in_address,
  input  wire logic [fes_pkg::PAGE_W-1:0]      in_page_number,
  input  wire logic [fes_pkg::BYTE_W-1:0]      in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [fes_pkg::BYTE_W-1:0]      out_read_data,
  output logic      [fes_pkg::STATUS_W-1:0]    out_status,
  output logic      [fes_pkg::ERASED_W-1:0]    out_pages_erased,
  output logic      [fes_pkg::PROG_W-1:0]      out_bytes_programmed,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fes_pkg::REGION_W-1:0]    cfg_region_size
);

  localparam int AW        = $clog2(STORE_BYTES);
  localparam int OW        = $clog2(PAGE_BYTES);
  localparam int EW        = fes_pkg::EXT_W;
  localparam int LAST_BASE = (STORE_BYTES / PAGE_BYTES) * PAGE_BYTES;
  localparam int PART      = STORE_BYTES - LAST_BASE;

  fes_pkg::ctl_t   ctl;
  fes_pkg::flags_t flags;

  logic [fes_pkg::REGION_W-1:0] region_r, region_nxt;
  logic [fes_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [fes_pkg::PAGE_W-1:0]   page_r, page_nxt;
  logic [fes_pkg::BYTE_W-1:0]   data_r, data_nxt;
  logic [AW-1:0]                ptr_r, ptr_nxt;
  logic [OW-1:0]                off_r, off_nxt;
  logic [fes_pkg::ERASED_W-1:0] cnt_r, cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [fes_pkg::BYTE_W-1:0]    out_rdata_r, out_rdata_nxt;
  logic [fes_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [fes_pkg::ERASED_W-1:0]  out_erased_r, out_erased_nxt;
  logic [fes_pkg::PROG_W-1:0]    out_prog_r, out_prog_nxt;

  logic                          accept;
  logic                          out_free;
  logic                          fire;
  logic [EW-1:0]                 size;
  logic                          in_range;
  logic [EW-1:0]                 page_base;
  logic [EW-1:0]                 next_base;
  logic                          page_end;
  logic [fes_pkg::PROG_W-1:0]    prog_full;
  logic [fes_pkg::BYTE_W-1:0]    q;
  logic                          mem_wr_en;
  logic [AW-1:0]                 mem_wr_addr;
  logic [fes_pkg::BYTE_W-1:0]    mem_wr_data;

  logic [fes_pkg::BYTE_W-1:0]    res_rdata;
  logic [fes_pkg::STATUS_W-1:0]  res_status;
  logic [fes_pkg::ERASED_W-1:0]  res_erased;
  logic [fes_pkg::PROG_W-1:0]    res_prog;

  // Handshakes.
  assign in_stall  = !ctl.take;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = ctl.emit && out_free;

  // Region limits, bounded by the store.
  assign size = (EW'(region_r) < EW'(STORE_BYTES)) ? EW'(region_r) : EW'(STORE_BYTES);
  assign in_range  = EW'(addr_r) < size;
  assign page_base = EW'(page_r) * EW'(PAGE_BYTES);
  assign next_base = EW'(ptr_r) + EW'(1);
  assign page_end  = off_r == OW'(PAGE_BYTES - 1);

  // Program count of an erase-and-reprogram write: the page bytes inside the store.
  assign prog_full = (EW'(addr_r) >= EW'(LAST_BASE)) ? fes_pkg::PROG_W'(PART)
                                                     : fes_pkg::PROG_W'(PAGE_BYTES);

  // Conditions for the sequencer.
  always_comb begin
    flags.item     = accept;
    flags.out_free = out_free;
    flags.clr_done = ptr_r == AW'(STORE_BYTES - 1);
    flags.page_bad = (page_base + EW'(PAGE_BYTES)) > size;
    flags.no_pages = EW'(PAGE_BYTES) > size;
    flags.page_end = page_end;
    flags.all_end  = page_end && ((next_base + EW'(PAGE_BYTES)) > size);
    flags.op       = in_operation;
  end

  fes_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  // Memory write: erase fill at the walk pointer, or the item's byte when it is in range and differs.
  always_comb begin
    unique case (ctl.wr)
      fes_pkg::WR_FF: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_r;
        mem_wr_data = fes_pkg::ERASED_BYTE;
      end
      fes_pkg::WR_DATA: begin
        mem_wr_en   = fire && in_range && (q != data_r);
        mem_wr_addr = addr_r[AW-1:0];
        mem_wr_data = data_r;
      end
      default: begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = ptr_r;
        mem_wr_data = fes_pkg::ERASED_BYTE;
      end
    endcase
  end

  fes_mem #(
    .DEPTH (STORE_BYTES)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_address[AW-1:0]),
    .rd_data (q),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Result of the finishing step.
  always_comb begin
    res_rdata  = '0;
    res_status = fes_pkg::ST_OK;
    res_erased = '0;
    res_prog   = '0;
    case (ctl.res)
      fes_pkg::RES_READ: begin
        res_rdata = in_range ? q : fes_pkg::ERASED_BYTE;
      end
      fes_pkg::RES_WRITE: begin
        if (!in_range) begin
          res_status = fes_pkg::ST_INVALID;
        end else if (q != data_r) begin
          if ((q & data_r) != data_r) begin
            res_erased = fes_pkg::ERASED_W'(1);
            res_prog   = prog_full;
          end else begin
            res_prog = fes_pkg::PROG_W'(1);
          end
        end
      end
      fes_pkg::RES_VERIFY: begin
        if (!in_range) begin
          res_status = fes_pkg::ST_INVALID;
        end else if (q != data_r) begin
          res_status = fes_pkg::ST_MISMATCH;
        end
      end
      fes_pkg::RES_ERASE: begin
        res_erased = cnt_r;
      end
      fes_pkg::RES_INVALID: begin
        res_status = fes_pkg::ST_INVALID;
      end
      default: begin
        res_status = fes_pkg::ST_OK;
      end
    endcase
  end

  // Next values of the datapath and output registers.
  always_comb begin
    region_nxt     = region_r;
    addr_nxt       = addr_r;
    page_nxt       = page_r;
    data_nxt       = data_r;
    ptr_nxt        = ptr_r;
    off_nxt        = off_r;
    cnt_nxt        = cnt_r;
    out_rdata_nxt  = out_rdata_r;
    out_status_nxt = out_status_r;
    out_erased_nxt = out_erased_r;
    out_prog_nxt   = out_prog_r;

    if (cfg_valid && cfg_ready) begin
      region_nxt = cfg_region_size;
    end

    if (accept) begin
      addr_nxt = in_address;
      page_nxt = in_page_number;
      data_nxt = in_data;
    end

    case (ctl.act)
      fes_pkg::ACT_SETUP_PAGE: begin
        ptr_nxt = page_base[AW-1:0];
        off_nxt = '0;
        cnt_nxt = '0;
      end
      fes_pkg::ACT_SETUP_ALL: begin
        ptr_nxt = '0;
        off_nxt = '0;
        cnt_nxt = '0;
      end
      fes_pkg::ACT_WALK: begin
        ptr_nxt = ptr_r + AW'(1);
        if (page_end) begin
          off_nxt = '0;
          if (cnt_r != fes_pkg::ERASED_MAX) begin
            cnt_nxt = cnt_r + fes_pkg::ERASED_W'(1);
          end
        end else begin
          off_nxt = off_r + OW'(1);
        end
      end
      default: begin
        ptr_nxt = ptr_r;
      end
    endcase

    if (fire) begin
      out_rdata_nxt  = res_rdata;
      out_status_nxt = res_status;
      out_erased_nxt = res_erased;
      out_prog_nxt   = res_prog;
    end

    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r    <= fes_pkg::REGION_RESET;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      region_r    <= region_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    page_r       <= page_nxt;
    data_r       <= data_nxt;
    off_r        <= off_nxt;
    cnt_r        <= cnt_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_status_r <= out_status_nxt;
    out_erased_r <= out_erased_nxt;
    out_prog_r   <= out_prog_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_read_data        = out_rdata_r;
  assign out_status           = out_status_r;
  assign out_pages_erased     = out_erased_r;
  assign out_bytes_programmed = out_prog_r;

  // Once an item is taken, no further item enters until its routine is done.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("item accepted while another was in progress");

  // A result is never produced in the same cycle as an item is taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !accept)
    else $error("result and new item in the same cycle");

  // The item's byte is only written for an in-range write that delivers its result.
  a_data_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && ctl.wr == fes_pkg::WR_DATA) |-> (in_range && fire))
    else $error("byte written outside an in-range write");

  // The erase-all walk ends in the erase result step.
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cond == fes_pkg::C_ALL_END && flags.all_end) |=> (ctl.res == fes_pkg::RES_ERASE))
    else $error("erase walk did not finish in the result step");

endmodule

`default_nettype wire
